>>> sv/scar_pkg.sv
// shared types, constants and ring geometry functions of the stereo reverb core
package scar_pkg;

    localparam int WORD_W = 32;

    localparam int SAMPLE_BITS_DEF     = 32;
    localparam int COMB_LONGEST_DEF    = 728;
    localparam int ALLPASS_LONGEST_DEF = 13;

    localparam int COMB_RINGS    = 6;
    localparam int ALLPASS_RINGS = 2;

    localparam int COMB_NOMINAL [COMB_RINGS]       = '{728, 700, 680, 654, 610, 587};
    localparam int ALLPASS_NOMINAL [ALLPASS_RINGS] = '{13, 12};

    localparam logic [WORD_W-1:0] COMB_DECAY_RST   = 32'h7333_3333;
    localparam logic [WORD_W-1:0] ALLPASS_COEF_RST = 32'h1fff_ffff;
    localparam logic [WORD_W-1:0] COMB_GAIN_RST    = 32'h3fff_ffff;
    localparam logic [WORD_W-1:0] WET_MIX_RST      = 32'h3333_3333;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COMB_DECAY   = 2'd0,
        CFG_ALLPASS_COEF = 2'd1,
        CFG_COMB_GAIN    = 2'd2,
        CFG_WET_MIX      = 2'd3
    } t_cfg_reg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WET_MUL,
        ST_DRYL_MUL,
        ST_DRYR_MUL,
        ST_COMB0,
        ST_COMB1,
        ST_COMB2,
        ST_COMB3,
        ST_COMB4,
        ST_COMB5,
        ST_GAIN,
        ST_AP0_RD,
        ST_AP0_NEW,
        ST_AP0_OUT,
        ST_AP1_NEW,
        ST_AP1_OUT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic adv;
    } t_store_ctl;

    // ring length, cut to the longest allowed
    function automatic int ring_len(input bit is_comb, input int idx, input int longest);
        int nominal;
        if (is_comb) begin
            nominal = (idx < COMB_RINGS) ? COMB_NOMINAL[idx] : 1;
        end else begin
            nominal = (idx < ALLPASS_RINGS) ? ALLPASS_NOMINAL[idx] : 1;
        end
        return (nominal > longest) ? longest : nominal;
    endfunction

    // first entry of a ring in the packed store
    function automatic int ring_base(input bit is_comb, input int idx, input int longest);
        int base;
        base = 0;
        for (int k = 0; k < COMB_RINGS; k++) begin
            if (k < idx) begin
                base = base + ring_len(is_comb, k, longest);
            end
        end
        return base;
    endfunction

endpackage

>>> sv/scar_in_if.sv
// input channel: one stereo sample pair per word
interface scar_in_if;
    logic                        valid;
    logic                        ready;
    logic [scar_pkg::WORD_W-1:0] left_in;
    logic [scar_pkg::WORD_W-1:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink (input valid, input left_in, input right_in, output ready);
endinterface

>>> sv/scar_out_if.sv
// output channel: one processed stereo sample pair per word
interface scar_out_if;
    logic                        valid;
    logic                        ready;
    logic [scar_pkg::WORD_W-1:0] left_out;
    logic [scar_pkg::WORD_W-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink (input valid, input left_out, input right_out, output ready);
endinterface

>>> sv/stereo_comb_allpass_reverb_core.sv
// top level of the stereo comb and allpass reverb: sequencer, datapath and config registers
// throughput: one stereo pair is worked on at a time, bounded by the single shared
//   q31 multiplier (14 products per pair) and the one read and one write port of each
//   delay store
// reset: config registers take their reset values, ring positions and fill counts go to zero;
//   a store entry reads as zero until its ring has been written once, so no clearing pass
module stereo_comb_allpass_reverb_core #(
    parameter int SAMPLE_BITS     = scar_pkg::SAMPLE_BITS_DEF,
    parameter int COMB_LONGEST    = scar_pkg::COMB_LONGEST_DEF,
    parameter int ALLPASS_LONGEST = scar_pkg::ALLPASS_LONGEST_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    scar_in_if.sink                          i_in,
    scar_out_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  logic [scar_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [scar_pkg::WORD_W-1:0]      i_cfg_data
);

    localparam int W        = scar_pkg::WORD_W;
    localparam int WRAP_SH  = W - SAMPLE_BITS;
    localparam int C_RING_W = $clog2(scar_pkg::COMB_RINGS);
    localparam int A_RING_W = $clog2(scar_pkg::ALLPASS_RINGS);

    // wrap a 32-bit value to the sample width, sign extended
    function automatic logic [W-1:0] wrap(input logic [W-1:0] v);
        logic signed [W-1:0] s;
        s = signed'(v << WRAP_SH);
        return s >>> WRAP_SH;
    endfunction

    function automatic logic [W-1:0] asr(input logic [W-1:0] v, input int n);
        return signed'(v) >>> n;
    endfunction

    // config registers
    logic [W-1:0] r_decay;
    logic [W-1:0] r_coef;
    logic [W-1:0] r_gain;
    logic [W-1:0] r_mix;

    // input skid register, lets a word in while the previous pair is in flight
    logic         r_ib_full;
    logic [W-1:0] r_ib_l;
    logic [W-1:0] r_ib_r;

    // output register
    logic         r_ov;
    logic [W-1:0] r_ol;
    logic [W-1:0] r_or;

    // sequencer
    scar_pkg::t_state r_state;
    scar_pkg::t_state n_state;

    // datapath registers
    logic [W-1:0] r_x;      // wet feed before the mix product
    logic [W-1:0] r_l;      // dry left, attenuated in two steps
    logic [W-1:0] r_r;      // dry right
    logic [W-1:0] r_wet;
    logic [W-1:0] r_sum;    // sum of the six comb reads
    logic [W-1:0] r_t;      // scaled comb sum into the first allpass
    logic [W-1:0] r_old0;
    logic [W-1:0] r_old1;
    logic [W-1:0] r_nw;
    logic [W-1:0] r_q;      // coef times old entry of the second allpass

    logic                 w_load;
    logic                 w_out_wr;
    logic                 w_out_free;
    logic                 w_mul_en;
    logic [W-1:0]         w_mul_a;
    logic [W-1:0]         w_mul_b;
    logic [W-1:0]         w_prod;
    scar_pkg::t_store_ctl w_comb_ctl;
    scar_pkg::t_store_ctl w_ap_ctl;
    logic [C_RING_W-1:0]  w_comb_ring;
    logic [A_RING_W-1:0]  w_ap_ring;
    logic [W-1:0]         w_comb_rd;
    logic [W-1:0]         w_ap_rd;
    logic [SAMPLE_BITS-1:0] w_comb_wd;
    logic [SAMPLE_BITS-1:0] w_ap_wd;

    logic [W-1:0] w_li;
    logic [W-1:0] w_ri;
    logic [W-1:0] w_x;
    logic [W-1:0] w_l1;
    logic [W-1:0] w_r1;
    logic [W-1:0] w_nw0;
    logic [W-1:0] w_t0;
    logic [W-1:0] w_nw1;
    logic [W-1:0] w_t1;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay <= scar_pkg::COMB_DECAY_RST;
            r_coef  <= scar_pkg::ALLPASS_COEF_RST;
            r_gain  <= scar_pkg::COMB_GAIN_RST;
            r_mix   <= scar_pkg::WET_MIX_RST;
        end else if (i_cfg_we) begin
            unique case (scar_pkg::t_cfg_reg'(i_cfg_idx))
                scar_pkg::CFG_COMB_DECAY:   r_decay <= i_cfg_data;
                scar_pkg::CFG_ALLPASS_COEF: r_coef  <= i_cfg_data;
                scar_pkg::CFG_COMB_GAIN:    r_gain  <= i_cfg_data;
                scar_pkg::CFG_WET_MIX:      r_mix   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front end: wet feed and first dry attenuation, taken straight from the skid register
    always_comb begin
        w_li = wrap(r_ib_l);
        w_ri = wrap(r_ib_r);
        w_x  = wrap(asr(w_li, 4) + asr(w_li, 6) + asr(w_ri, 4) + asr(w_ri, 6));
        w_l1 = wrap(w_li - asr(w_li, 4));
        w_r1 = wrap(w_ri - asr(w_ri, 4));
    end

    // allpass arithmetic around the shared product
    always_comb begin
        w_nw0 = wrap(r_t - w_prod);
        w_t0  = wrap(r_old0 + w_prod);
        w_nw1 = wrap(w_t0 - r_q);
        w_t1  = wrap(r_old1 + w_prod);
    end

    assign w_comb_wd  = SAMPLE_BITS'(wrap(r_wet + w_prod));
    assign w_ap_wd    = SAMPLE_BITS'((r_state == scar_pkg::ST_AP1_NEW) ? w_nw1 : w_nw0);
    assign w_out_free = !r_ov || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scar_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // schedule: one product per cycle bar AP1_NEW, DONE, IDLE; store reads land when multiplied
    always_comb begin
        n_state     = r_state;
        w_load      = 1'b0;
        w_out_wr    = 1'b0;
        w_mul_en    = 1'b0;
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_comb_ctl  = '0;
        w_ap_ctl    = '0;
        w_comb_ring = '0;
        w_ap_ring   = '0;
        unique case (r_state)
            scar_pkg::ST_IDLE: begin
                if (r_ib_full) begin
                    w_load  = 1'b1;
                    n_state = scar_pkg::ST_WET_MUL;
                end
            end
            scar_pkg::ST_WET_MUL: begin
                w_mul_en = 1'b1;
                w_mul_a  = r_x;
                w_mul_b  = r_mix;
                n_state  = scar_pkg::ST_DRYL_MUL;
            end
            scar_pkg::ST_DRYL_MUL: begin
                w_mul_en = 1'b1;
                w_mul_a  = r_l;
                w_mul_b  = r_mix;
                n_state  = scar_pkg::ST_DRYR_MUL;
            end
            scar_pkg::ST_DRYR_MUL: begin
                w_mul_en         = 1'b1;
                w_mul_a          = r_r;
                w_mul_b          = r_mix;
                w_comb_ctl.rd_en = 1'b1;
                w_comb_ring      = C_RING_W'(0);
                n_state          = scar_pkg::ST_COMB0;
            end
            scar_pkg::ST_COMB0: begin
                w_mul_en         = 1'b1;
                w_mul_a          = w_comb_rd;
                w_mul_b          = r_decay;
                w_comb_ctl.rd_en = 1'b1;
                w_comb_ring      = C_RING_W'(1);
                n_state          = scar_pkg::ST_COMB1;
            end
            scar_pkg::ST_COMB1: begin
                w_mul_en         = 1'b1;
                w_mul_a          = w_comb_rd;
                w_mul_b          = r_decay;
                w_comb_ctl.rd_en = 1'b1;
                w_comb_ctl.wr_en = 1'b1;
                w_comb_ring      = C_RING_W'(2);
                n_state          = scar_pkg::ST_COMB2;
            end
            scar_pkg::ST_COMB2: begin
                w_mul_en         = 1'b1;
                w_mul_a          = w_comb_rd;
                w_mul_b          = r_decay;
                w_comb_ctl.rd_en = 1'b1;
                w_comb_ctl.wr_en = 1'b1;
                w_comb_ring      = C_RING_W'(3);
                n_state          = scar_pkg::ST_COMB3;
            end
            scar_pkg::ST_COMB3: begin
                w_mul_en         = 1'b1;
                w_mul_a          = w_comb_rd;
                w_mul_b          = r_decay;
                w_comb_ctl.rd_en = 1'b1;
                w_comb_ctl.wr_en = 1'b1;
                w_comb_ring      = C_RING_W'(4);
                n_state          = scar_pkg::ST_COMB4;
            end
            scar_pkg::ST_COMB4: begin
                w_mul_en         = 1'b1;
                w_mul_a          = w_comb_rd;
                w_mul_b          = r_decay;
                w_comb_ctl.rd_en = 1'b1;
                w_comb_ctl.wr_en = 1'b1;
                w_comb_ring      = C_RING_W'(5);
                n_state          = scar_pkg::ST_COMB5;
            end
            scar_pkg::ST_COMB5: begin
                w_mul_en         = 1'b1;
                w_mul_a          = w_comb_rd;
                w_mul_b          = r_decay;
                w_comb_ctl.wr_en = 1'b1;
                n_state          = scar_pkg::ST_GAIN;
            end
            scar_pkg::ST_GAIN: begin
                w_mul_en         = 1'b1;
                w_mul_a          = wrap(r_sum);
                w_mul_b          = r_gain;
                w_comb_ctl.wr_en = 1'b1;
                w_ap_ctl.rd_en   = 1'b1;
                w_ap_ring        = A_RING_W'(0);
                n_state          = scar_pkg::ST_AP0_RD;
            end
            scar_pkg::ST_AP0_RD: begin
                w_mul_en       = 1'b1;
                w_mul_a        = w_ap_rd;
                w_mul_b        = r_coef;
                w_ap_ctl.rd_en = 1'b1;
                w_ap_ring      = A_RING_W'(1);
                n_state        = scar_pkg::ST_AP0_NEW;
            end
            scar_pkg::ST_AP0_NEW: begin
                w_mul_en       = 1'b1;
                w_mul_a        = w_ap_rd;
                w_mul_b        = r_coef;
                w_ap_ctl.wr_en = 1'b1;
                n_state        = scar_pkg::ST_AP0_OUT;
            end
            scar_pkg::ST_AP0_OUT: begin
                w_mul_en = 1'b1;
                w_mul_a  = r_nw;
                w_mul_b  = r_coef;
                n_state  = scar_pkg::ST_AP1_NEW;
            end
            scar_pkg::ST_AP1_NEW: begin
                w_ap_ctl.wr_en = 1'b1;
                n_state        = scar_pkg::ST_AP1_OUT;
            end
            scar_pkg::ST_AP1_OUT: begin
                w_mul_en = 1'b1;
                w_mul_a  = r_nw;
                w_mul_b  = r_coef;
                n_state  = scar_pkg::ST_DONE;
            end
            scar_pkg::ST_DONE: begin
                // the last product holds while the output register is full
                if (w_out_free) begin
                    w_out_wr        = 1'b1;
                    w_comb_ctl.adv  = 1'b1;
                    w_ap_ctl.adv    = 1'b1;
                    if (r_ib_full) begin
                        w_load  = 1'b1;
                        n_state = scar_pkg::ST_WET_MUL;
                    end else begin
                        n_state = scar_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = scar_pkg::ST_IDLE;
            end
        endcase
    end

    // handshake control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ib_full <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (i_in.valid && !r_ib_full) begin
                r_ib_full <= 1'b1;
            end else if (w_load) begin
                r_ib_full <= 1'b0;
            end
            if (w_out_wr) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_in.valid && !r_ib_full) begin
            r_ib_l <= i_in.left_in;
            r_ib_r <= i_in.right_in;
        end
        if (w_load) begin
            r_x <= w_x;
            r_l <= w_l1;
            r_r <= w_r1;
        end
        unique case (r_state)
            scar_pkg::ST_DRYL_MUL: r_wet <= wrap(w_prod);
            scar_pkg::ST_DRYR_MUL: r_l   <= wrap(r_l - w_prod);
            scar_pkg::ST_COMB0: begin
                r_r   <= wrap(r_r - w_prod);
                r_sum <= w_comb_rd;
            end
            scar_pkg::ST_COMB1,
            scar_pkg::ST_COMB2,
            scar_pkg::ST_COMB3,
            scar_pkg::ST_COMB4,
            scar_pkg::ST_COMB5: r_sum <= r_sum + w_comb_rd;
            scar_pkg::ST_AP0_RD: begin
                r_t    <= wrap(w_prod);
                r_old0 <= w_ap_rd;
            end
            scar_pkg::ST_AP0_NEW: begin
                r_nw   <= w_nw0;
                r_old1 <= w_ap_rd;
            end
            scar_pkg::ST_AP0_OUT: r_q  <= w_prod;
            scar_pkg::ST_AP1_NEW: r_nw <= w_nw1;
            scar_pkg::ST_DONE: begin
                if (w_out_wr) begin
                    r_ol <= wrap(r_l + w_t1);
                    r_or <= wrap(r_r - w_t1);
                end
            end
            default: ;
        endcase
    end

    scar_fmul u_fmul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    scar_ring_store #(
        .IS_COMB   (1'b1),
        .NUM_RINGS (scar_pkg::COMB_RINGS),
        .LONGEST   (COMB_LONGEST),
        .DATA_W    (SAMPLE_BITS)
    ) u_comb_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_comb_ctl),
        .i_rd_ring (w_comb_ring),
        .i_wr_data (w_comb_wd),
        .o_rd_data (w_comb_rd)
    );

    scar_ring_store #(
        .IS_COMB   (1'b0),
        .NUM_RINGS (scar_pkg::ALLPASS_RINGS),
        .LONGEST   (ALLPASS_LONGEST),
        .DATA_W    (SAMPLE_BITS)
    ) u_ap_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ap_ctl),
        .i_rd_ring (w_ap_ring),
        .i_wr_data (w_ap_wd),
        .o_rd_data (w_ap_rd)
    );

    assign i_in.ready      = !r_ib_full;
    assign o_out.valid     = r_ov;
    assign o_out.left_out  = r_ol;
    assign o_out.right_out = r_or;

endmodule

>>> sv/scar_fmul.sv
// shared q31 fractional multiplier, truncating toward minus infinity, registered result
module scar_fmul (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [scar_pkg::WORD_W-1:0] i_a,
    input  logic signed [scar_pkg::WORD_W-1:0] i_b,
    output logic        [scar_pkg::WORD_W-1:0] o_prod
);

    logic signed [2*scar_pkg::WORD_W-1:0] w_full;
    logic        [scar_pkg::WORD_W-1:0]   r_prod;

    assign w_full = i_a * i_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= w_full[2*scar_pkg::WORD_W-2:scar_pkg::WORD_W-1];
        end
    end

    assign o_prod = r_prod;

endmodule

>>> sv/scar_ring_store.sv
// packed ring delay store with write positions, fill count and queued write addresses
module scar_ring_store #(
    parameter bit IS_COMB   = 1'b1,
    parameter int NUM_RINGS = scar_pkg::COMB_RINGS,
    parameter int LONGEST   = scar_pkg::COMB_LONGEST_DEF,
    parameter int DATA_W    = scar_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  scar_pkg::t_store_ctl           i_ctl,
    input  logic [$clog2(NUM_RINGS)-1:0]   i_rd_ring,
    input  logic [DATA_W-1:0]              i_wr_data,
    output logic [scar_pkg::WORD_W-1:0]    o_rd_data
);

    localparam int DEPTH  = scar_pkg::ring_base(IS_COMB, NUM_RINGS, LONGEST);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int MAXLEN = scar_pkg::ring_len(IS_COMB, 0, LONGEST);
    localparam int POS_W  = $clog2(MAXLEN);
    localparam int WQ_DEPTH = 4;
    localparam int WQ_W     = $clog2(WQ_DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;
    logic              r_rvld;

    logic [POS_W-1:0]  r_pos [NUM_RINGS];
    logic [POS_W-1:0]  r_fill;

    logic [ADDR_W-1:0] r_wq [WQ_DEPTH];
    logic [WQ_W-1:0]   r_wq_wp;
    logic [WQ_W-1:0]   r_wq_rp;

    logic [ADDR_W-1:0] w_base;
    logic [POS_W-1:0]  w_pos;
    logic [POS_W-1:0]  w_last;
    logic [POS_W-1:0]  w_rp;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [ADDR_W-1:0] w_wr_addr;
    logic              w_filled;

    // the entry after the write position was written once the ring has lapped
    always_comb begin
        w_base    = ADDR_W'(scar_pkg::ring_base(IS_COMB, int'(i_rd_ring), LONGEST));
        w_last    = POS_W'(scar_pkg::ring_len(IS_COMB, int'(i_rd_ring), LONGEST) - 1);
        w_pos     = r_pos[i_rd_ring];
        w_rp      = (w_pos == w_last) ? '0 : w_pos + 1'b1;
        w_rd_addr = w_base + ADDR_W'(w_rp);
        w_wr_addr = w_base + ADDR_W'(w_pos);
        w_filled  = (r_fill >= w_last);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[r_wq[r_wq_rp]] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
        if (i_ctl.rd_en) begin
            r_wq[r_wq_wp] <= w_wr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvld  <= 1'b0;
            r_fill  <= '0;
            r_wq_wp <= '0;
            r_wq_rp <= '0;
            for (int k = 0; k < NUM_RINGS; k++) begin
                r_pos[k] <= '0;
            end
        end else begin
            if (i_ctl.rd_en) begin
                r_rvld  <= w_filled;
                r_wq_wp <= r_wq_wp + 1'b1;
            end
            if (i_ctl.wr_en) begin
                r_wq_rp <= r_wq_rp + 1'b1;
            end
            if (i_ctl.adv) begin
                if (r_fill != POS_W'(MAXLEN - 1)) begin
                    r_fill <= r_fill + 1'b1;
                end
                for (int k = 0; k < NUM_RINGS; k++) begin
                    if (r_pos[k] == POS_W'(scar_pkg::ring_len(IS_COMB, k, LONGEST) - 1)) begin
                        r_pos[k] <= '0;
                    end else begin
                        r_pos[k] <= r_pos[k] + 1'b1;
                    end
                end
            end
        end
    end

    assign o_rd_data = r_rvld ? scar_pkg::WORD_W'(signed'(r_rdata)) : '0;

endmodule

>>> tb/stereo_comb_allpass_reverb_core_test.sv
// self-checking bench of the stereo comb and allpass reverb core, prediction against a local model
module stereo_comb_allpass_reverb_core_test;
    import scar_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] left;
        logic [WORD_W-1:0] right;
    } stereo_pair_t;

    localparam logic [WORD_W-1:0] Q31_MIN = 32'h8000_0000;
    localparam logic [WORD_W-1:0] Q31_MAX = 32'h7fff_ffff;

    // clock, reset and configuration port
    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = CFG_COMB_DECAY;
    logic [WORD_W-1:0]    cfg_data = '0;

    // stream side registers, known from time zero
    logic              src_valid = 1'b0;
    logic [WORD_W-1:0] src_left  = '0;
    logic [WORD_W-1:0] src_right = '0;
    logic              snk_ready = 1'b0;

    // words waiting to be sent and output pairs waiting to be seen
    stereo_pair_t pending_pairs[$];
    stereo_pair_t expected_out_pairs[$];

    int  mismatches = 0;
    int  send_gap   = 0;
    int  stall_left = 0;
    bit  in_taken   = 1'b0;
    // no idling on either side during the last stretch of the run
    bit  quiet      = 1'b0;

    // local copy of the core state: delay rings, write positions and coefficients
    logic [WORD_W-1:0] comb_ring [COMB_RINGS][COMB_LONGEST_DEF];
    logic [WORD_W-1:0] ap_ring [ALLPASS_RINGS][ALLPASS_LONGEST_DEF];
    int                comb_pos [COMB_RINGS];
    int                ap_pos [ALLPASS_RINGS];
    logic [WORD_W-1:0] decay_q31;
    logic [WORD_W-1:0] coef_q31;
    logic [WORD_W-1:0] gain_q31;
    logic [WORD_W-1:0] mix_q31;

    scar_in_if  in_bus ();
    scar_out_if out_bus ();

    assign in_bus.valid    = src_valid;
    assign in_bus.left_in  = src_left;
    assign in_bus.right_in = src_right;
    assign out_bus.ready   = snk_ready;

    stereo_comb_allpass_reverb_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_bus),
        .o_out      (out_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // q31 product, floor of the 64-bit product over 2^31, low 32 bits kept
    function automatic logic [WORD_W-1:0] q31_mul(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
        longint prod;
        longint shifted;
        prod    = longint'($signed(a)) * longint'($signed(b));
        shifted = prod >>> 31;
        return shifted[WORD_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] sra(logic [WORD_W-1:0] x, int n);
        return $signed(x) >>> n;
    endfunction

    // one sample of the reverb: advances the local rings and returns the output pair
    function automatic stereo_pair_t reverb_pair(stereo_pair_t x);
        logic [WORD_W-1:0] l, r, wet, acc, rd, old, fresh, t;
        int                len, wpos, rpos;
        stereo_pair_t      y;
        wet = q31_mul(sra(x.left, 4) + sra(x.left, 6) + sra(x.right, 4) + sra(x.right, 6),
                      mix_q31);
        // dry attenuation: first by a sixteenth, then by the mix
        l = x.left - sra(x.left, 4);
        r = x.right - sra(x.right, 4);
        l = l - q31_mul(l, mix_q31);
        r = r - q31_mul(r, mix_q31);
        acc = '0;
        for (int k = 0; k < COMB_RINGS; k++) begin
            len = COMB_NOMINAL[k];
            if (len > COMB_LONGEST_DEF) begin
                len = COMB_LONGEST_DEF;
            end
            wpos = comb_pos[k];
            rpos = (wpos + 1) % len;
            rd   = comb_ring[k][rpos];
            comb_ring[k][wpos] = wet + q31_mul(rd, decay_q31);
            acc  = acc + rd;
            comb_pos[k] = rpos;
        end
        t = q31_mul(acc, gain_q31);
        for (int k = 0; k < ALLPASS_RINGS; k++) begin
            len = ALLPASS_NOMINAL[k];
            if (len > ALLPASS_LONGEST_DEF) begin
                len = ALLPASS_LONGEST_DEF;
            end
            wpos  = ap_pos[k];
            rpos  = (wpos + 1) % len;
            old   = ap_ring[k][rpos];
            fresh = t - q31_mul(old, coef_q31);
            ap_ring[k][wpos] = fresh;
            t     = old + q31_mul(fresh, coef_q31);
            ap_pos[k] = rpos;
        end
        y.left  = l + t;
        y.right = r - t;
        return y;
    endfunction

    // monitor: tracks config writes and accepted words, checks every output word
    always @(posedge i_clk) begin : monitor
        stereo_pair_t got;
        stereo_pair_t want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
            for (int k = 0; k < COMB_RINGS; k++) begin
                comb_pos[k] = 0;
                for (int e = 0; e < COMB_LONGEST_DEF; e++) begin
                    comb_ring[k][e] = '0;
                end
            end
            for (int k = 0; k < ALLPASS_RINGS; k++) begin
                ap_pos[k] = 0;
                for (int e = 0; e < ALLPASS_LONGEST_DEF; e++) begin
                    ap_ring[k][e] = '0;
                end
            end
            decay_q31 = COMB_DECAY_RST;
            coef_q31  = ALLPASS_COEF_RST;
            gain_q31  = COMB_GAIN_RST;
            mix_q31   = WET_MIX_RST;
        end else begin
            in_taken <= in_bus.valid && in_bus.ready;
            if (cfg_we) begin
                case (t_cfg_reg'(cfg_idx))
                    CFG_COMB_DECAY:   decay_q31 = cfg_data;
                    CFG_ALLPASS_COEF: coef_q31  = cfg_data;
                    CFG_COMB_GAIN:    gain_q31  = cfg_data;
                    CFG_WET_MIX:      mix_q31   = cfg_data;
                    default: ;
                endcase
            end
            if (in_bus.valid && in_bus.ready) begin
                got.left  = in_bus.left_in;
                got.right = in_bus.right_in;
                expected_out_pairs.push_back(reverb_pair(got));
            end
            if (out_bus.valid && out_bus.ready) begin
                got.left  = out_bus.left_out;
                got.right = out_bus.right_out;
                if (expected_out_pairs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected output word %h %h", got.left, got.right);
                    end
                end else begin
                    want = expected_out_pairs.pop_front();
                    if (got.left !== want.left || got.right !== want.right) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: expected left %h right %h, got left %h right %h",
                                     want.left, want.right, got.left, got.right);
                        end
                    end
                end
            end
        end
    end

    // driver: presents the next pending word once the current one is taken
    always @(negedge i_clk) begin : driver
        stereo_pair_t nxt;
        if (i_rst_n && (!src_valid || in_taken)) begin
            if (send_gap > 0) begin
                send_gap  <= send_gap - 1;
                src_valid <= 1'b0;
            end else if (pending_pairs.size() != 0) begin
                nxt        = pending_pairs.pop_front();
                src_valid <= 1'b1;
                src_left  <= nxt.left;
                src_right <= nxt.right;
                // sometimes idle for a burst after this word
                if (!quiet && $urandom_range(0, 3) == 0) begin
                    send_gap <= $urandom_range(1, 14);
                end
            end else begin
                src_valid <= 1'b0;
            end
        end
    end

    // receiver: ready high with random stall bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            snk_ready <= 1'b0;
        end else if (stall_left == 0 && !quiet && $urandom_range(0, 15) == 0) begin
            stall_left <= $urandom_range(1, 14);
            snk_ready  <= 1'b0;
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
            snk_ready  <= 1'b0;
        end else begin
            stall_left <= 0;
            snk_ready  <= 1'b1;
        end
    end

    task automatic queue_pair(logic [WORD_W-1:0] l, logic [WORD_W-1:0] r);
        stereo_pair_t p;
        p.left  = l;
        p.right = r;
        pending_pairs.push_back(p);
    endtask

    // wait until every queued word is sent and every output word has come back
    task automatic wait_drained();
        while (pending_pairs.size() != 0 || src_valid || expected_out_pairs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [WORD_W-1:0] value);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic set_coefs(logic [WORD_W-1:0] decay, logic [WORD_W-1:0] coef,
                             logic [WORD_W-1:0] gain, logic [WORD_W-1:0] mix);
        write_reg(CFG_COMB_DECAY, decay);
        write_reg(CFG_ALLPASS_COEF, coef);
        write_reg(CFG_COMB_GAIN, gain);
        write_reg(CFG_WET_MIX, mix);
    endtask

    // sample mix: extremes, small values around zero and full-range noise
    function automatic logic [WORD_W-1:0] random_sample();
        int small_val;
        case ($urandom_range(0, 9))
            0: return Q31_MIN;
            1: return Q31_MAX;
            2: return '0;
            3: return '1;
            4, 5: begin
                small_val = int'($urandom_range(0, 4095)) - 2048;
                return small_val;
            end
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] random_coef();
        case ($urandom_range(0, 4))
            0: return Q31_MIN;
            1: return Q31_MAX;
            2: return '0;
            default: return $urandom();
        endcase
    endfunction

    initial begin : stimulus
        int phases;
        phases = 8;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed words under reset coefficients: extremes, sign mixes, bit patterns
        queue_pair('0, '0);
        queue_pair(Q31_MAX, Q31_MAX);
        queue_pair(Q31_MIN, Q31_MIN);
        queue_pair(Q31_MAX, Q31_MIN);
        queue_pair(Q31_MIN, Q31_MAX);
        queue_pair('1, '1);
        queue_pair(32'd1, '1);
        queue_pair(32'haaaa_aaaa, 32'h5555_5555);
        queue_pair(32'h5555_5555, 32'haaaa_aaaa);
        queue_pair(32'h4000_0000, '0);
        queue_pair('0, 32'hc000_0000);
        queue_pair(32'd15, 32'hffff_fff0);
        wait_drained();

        // most negative coefficients: min by min products and wrapping sums
        set_coefs(Q31_MIN, Q31_MIN, Q31_MIN, Q31_MIN);
        queue_pair(Q31_MIN, Q31_MIN);
        queue_pair(Q31_MAX, Q31_MAX);
        queue_pair(Q31_MIN, Q31_MAX);
        queue_pair('1, '0);
        wait_drained();

        // most positive coefficients
        set_coefs(Q31_MAX, Q31_MAX, Q31_MAX, Q31_MAX);
        queue_pair(Q31_MAX, Q31_MIN);
        queue_pair(Q31_MIN, Q31_MIN);
        queue_pair(Q31_MAX, Q31_MAX);
        wait_drained();

        // zero coefficients: no wet feed; dry path plus old allpass ring entries
        set_coefs('0, '0, '0, '0);
        queue_pair(Q31_MAX, Q31_MIN);
        queue_pair(32'h1234_5678, 32'h8765_4321);
        wait_drained();

        // random phases, each with its own coefficient setting
        for (int p = 0; p < phases; p++) begin
            case (p)
                0: set_coefs(COMB_DECAY_RST, ALLPASS_COEF_RST, COMB_GAIN_RST, WET_MIX_RST);
                1: set_coefs(Q31_MIN, Q31_MIN, Q31_MIN, Q31_MIN);
                2: set_coefs(Q31_MAX, Q31_MAX, Q31_MAX, Q31_MAX);
                3: set_coefs('0, '0, '0, '0);
                default: set_coefs(random_coef(), random_coef(), random_coef(), random_coef());
            endcase
            if (p == phases - 1) begin
                quiet = 1'b1;
            end
            repeat (250) begin
                queue_pair(random_sample(), random_sample());
            end
            wait_drained();
        end

        // tail: let any stray output word show up
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && expected_out_pairs.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #6000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> files.f
sv/scar_pkg.sv
sv/scar_in_if.sv
sv/scar_out_if.sv
sv/scar_fmul.sv
sv/scar_ring_store.sv
sv/stereo_comb_allpass_reverb_core.sv
tb/stereo_comb_allpass_reverb_core_test.sv
